/* rtl/core/sjf_pkg.sv */
// Shared types and constants of the shortest-job-first dispatcher.
`default_nettype none
package sjf_pkg;

  // Fixed field widths of the stream payloads
  localparam int S_DATA_W = 16;
  localparam int ID_W     = 5;
  localparam int BURST_W  = 16;
  localparam int T_W      = 20;
  localparam int CNT_W    = 5;
  localparam int RESP_W   = 23;
  localparam int TURN_W   = 24;
  localparam int WAIT_W   = 23;

  // Internal time base: wide enough for every time field and total
  localparam int TIME_W   = 24;

  typedef enum logic [1:0] {
    ST_DISPATCHED = 2'd0,
    ST_REJECTED   = 2'd1,
    ST_EMPTY      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_ADVANCE,
    S_EMIT
  } state_t;

  // Result payload; the last member sits in the lowest bits
  typedef struct packed {
    logic [3:0]        pad;
    logic [WAIT_W-1:0] total_waiting;
    logic [TURN_W-1:0] total_turnaround;
    logic [RESP_W-1:0] total_response;
    logic [CNT_W-1:0]  count_done;
    logic [T_W-1:0]    wait_time;
    logic [T_W-1:0]    finish_time;
    logic [T_W-1:0]    start_time;
    logic [BURST_W-1:0] task_burst;
    logic [ID_W-1:0]   task_id;
  } result_data_t;

  localparam int M_DATA_W = $bits(result_data_t);

  // Controls from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic cmp_en;
  } sel_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/sjf_ram.sv */
// Generic single-port-write RAM with registered read.
`default_nettype none
module sjf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/sjf_select.sv */
// Shared compare unit: keeps the shortest valid burst seen during one table scan.
`default_nettype none
module sjf_select #(
  parameter int BW = 16,
  parameter int IW = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sjf_pkg::sel_ctrl_t ctrl,
  input  wire logic              cand_valid,
  input  wire logic [IW-1:0]     cand_idx,
  input  wire logic [BW-1:0]     cand_burst,
  output logic                   have,
  output logic      [IW-1:0]     best_idx,
  output logic      [BW-1:0]     best_burst
);
  import sjf_pkg::*;

  logic take;

  // Strict less-than over ascending indexes keeps the lower number on ties
  assign take = ctrl.cmp_en && cand_valid && (!have || (cand_burst < best_burst));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (ctrl.clear) begin
      have <= 1'b0;
    end else if (take) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctrl.clear) begin
      best_idx   <= cand_idx;
      best_burst <= cand_burst;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/shortest_job_first_dispatcher.sv */
// Top level of the shortest-job-first dispatcher: sequencer, task table and accumulators.
// An add is written on acceptance; a reject or empty-run result shows in the next cycle.
// Each pick of a run scans the whole table through the single RAM read port and one comparator,
// one entry per cycle; a run pauses while its result is stalled at the output.
// Throughput: one item at a time; s_tready is low from run start until its last result is loaded.
// Reset (synchronous, rst high) empties the table and idles the sequencer; RAM contents stay
// undefined and are only read behind a valid bit.
`default_nettype none
module shortest_job_first_dispatcher #(
  parameter int MAX_TASKS  = 16,
  parameter int BURST_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Input stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [sjf_pkg::S_DATA_W-1:0] s_tdata,   // burst[15:0]
  input  wire logic [0:0]                   s_tuser,   // mode[0]: 0 add, 1 run
  // Result stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [sjf_pkg::M_DATA_W-1:0] m_tdata,   // task_id, task_burst, start_time,
                                                       // finish_time, wait_time, count_done,
                                                       // total_response, total_turnaround,
                                                       // total_waiting, zero pad
  output logic      [1:0]                   m_tuser,   // status[1:0]
  output logic                              m_tlast    // final result of a run
);
  import sjf_pkg::*;

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int BW = (BURST_BITS < BURST_W) ? BURST_BITS : BURST_W;

  state_t           state, state_next;
  logic [IW-1:0]    idx;
  logic             cmp_v;
  logic [IW-1:0]    cmp_idx;
  logic [CW-1:0]    stored_count;
  logic [CW-1:0]    done_count;
  logic [MAX_TASKS-1:0] slot_valid;
  logic [TIME_W-1:0] clock_time;
  logic [TIME_W-1:0] start_r;
  logic [RESP_W-1:0] sum_response;
  logic [TURN_W-1:0] sum_turnaround;

  result_data_t     out_data;
  status_t          out_status;
  logic             out_last;

  logic             out_free;
  logic             s_accept;
  logic             is_run;
  logic             table_full;
  logic             table_empty;
  logic             scan_end;
  logic             run_last;
  logic             ram_we;
  logic             load_reject;
  logic             load_empty;
  logic             load_dispatch;
  logic             run_start;
  sel_ctrl_t        sel_ctrl;

  logic [BW-1:0]    ram_rdata;
  logic             have;
  logic [IW-1:0]    best_idx;
  logic [BW-1:0]    best_burst;
  logic [TIME_W-1:0] finish_w;

  assign out_free    = !m_tvalid || m_tready;
  assign s_accept    = s_tvalid && s_tready;
  assign is_run      = s_tuser[0];
  assign table_full  = (stored_count == CW'(MAX_TASKS));
  assign table_empty = (stored_count == '0);
  assign scan_end    = (idx == IW'(MAX_TASKS - 1));
  // done_count already counts the pick that is being emitted
  assign run_last    = (done_count == stored_count);
  assign finish_w    = clock_time;

  // Task table: written at the fill count, read at the scan index
  sjf_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stored_count[IW-1:0]),
    .wdata (s_tdata[BW-1:0]),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // One comparator, reused for every entry of every scan
  sjf_select #(
    .BW (BW),
    .IW (IW)
  ) u_select (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sel_ctrl),
    .cand_valid (slot_valid[cmp_idx]),
    .cand_idx   (cmp_idx),
    .cand_burst (ram_rdata),
    .have       (have),
    .best_idx   (best_idx),
    .best_burst (best_burst)
  );

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept && is_run && !table_empty) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:   state_next = S_ADVANCE;
      S_ADVANCE: state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = run_last ? S_IDLE : S_SCAN;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Output and strobe logic
  always_comb begin
    s_tready        = 1'b0;
    ram_we          = 1'b0;
    load_reject     = 1'b0;
    load_empty      = 1'b0;
    load_dispatch   = 1'b0;
    run_start       = 1'b0;
    sel_ctrl.clear  = 1'b0;
    sel_ctrl.cmp_en = cmp_v;
    case (state)
      S_IDLE: begin
        s_tready = out_free;
        if (s_accept) begin
          if (!is_run) begin
            ram_we      = !table_full;
            load_reject = table_full;
          end else begin
            load_empty = table_empty;
            run_start  = !table_empty;
          end
        end
      end
      S_SCAN: begin
        // No compare is in flight on the first scan cycle
        sel_ctrl.clear = (idx == '0);
      end
      S_EMIT: begin
        load_dispatch = out_free;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      idx            <= '0;
      cmp_v          <= 1'b0;
      stored_count   <= '0;
      done_count     <= '0;
      slot_valid     <= '0;
      clock_time     <= '0;
      sum_response   <= '0;
      sum_turnaround <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      cmp_v <= (state == S_SCAN);

      if (state == S_SCAN) begin
        idx <= scan_end ? '0 : idx + 1'b1;
      end

      if (ram_we) begin
        slot_valid[stored_count[IW-1:0]] <= 1'b1;
        stored_count <= stored_count + 1'b1;
      end

      if (run_start) begin
        done_count     <= '0;
        clock_time     <= '0;
        sum_response   <= '0;
        sum_turnaround <= '0;
      end

      // Retire the pick: advance the time line and accumulate response
      if (state == S_ADVANCE) begin
        slot_valid[best_idx] <= 1'b0;
        done_count   <= done_count + 1'b1;
        clock_time   <= clock_time + TIME_W'(best_burst);
        sum_response <= sum_response + RESP_W'(clock_time);
      end

      if (load_dispatch) begin
        sum_turnaround <= sum_turnaround + TURN_W'(finish_w);
        if (run_last) begin
          stored_count <= '0;
        end
      end

      if (load_reject || load_empty || load_dispatch) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmp_idx <= idx;
    if (state == S_ADVANCE) begin
      start_r <= clock_time;
    end
    if (load_reject) begin
      out_data   <= '0;
      out_status <= ST_REJECTED;
      out_last   <= 1'b0;
    end else if (load_empty) begin
      out_data   <= '0;
      out_status <= ST_EMPTY;
      out_last   <= 1'b1;
    end else if (load_dispatch) begin
      out_status           <= ST_DISPATCHED;
      out_last             <= run_last;
      out_data.pad         <= '0;
      out_data.task_id     <= ID_W'(CW'(best_idx) + 1'b1);
      out_data.task_burst  <= BURST_W'(best_burst);
      out_data.start_time  <= T_W'(start_r);
      out_data.finish_time <= T_W'(finish_w);
      // Waiting time equals start time when every task arrives at zero
      out_data.wait_time   <= T_W'(start_r);
      if (run_last) begin
        out_data.count_done       <= CNT_W'(done_count);
        out_data.total_response   <= sum_response;
        out_data.total_turnaround <= sum_turnaround + TURN_W'(finish_w);
        out_data.total_waiting    <= WAIT_W'(sum_response);
      end else begin
        out_data.count_done       <= '0;
        out_data.total_response   <= '0;
        out_data.total_turnaround <= '0;
        out_data.total_waiting    <= '0;
      end
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  // The compare unit always holds a pick when one is retired
  logic unused_have;
  assign unused_have = have;

endmodule
`default_nettype wire

/* rtl/core/sjf_checker.sv */
// Port-level checks of the dispatcher, bound to the top level.
`default_nettype none
module sjf_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic [sjf_pkg::S_DATA_W-1:0] s_tdata,
  input wire logic [0:0]                   s_tuser,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [sjf_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic [1:0]                   m_tuser,
  input wire logic                         m_tlast
);
  import sjf_pkg::*;

  result_data_t res;
  logic         in_seen;
  assign res     = m_tdata;
  assign in_seen = s_tvalid && (s_tdata != '0 || s_tuser != '0);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // Take no new item while a result is stalled
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_REJECTED |-> !m_tlast && res == '0)
    else $error("malformed reject result");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |-> m_tlast && res == '0)
    else $error("malformed empty-run result");

  a_wait: assert property (@(posedge clk) disable iff (rst || !in_seen && !m_tvalid)
    m_tvalid && m_tuser == ST_DISPATCHED |->
      res.wait_time == res.start_time
      && res.finish_time == res.start_time + T_W'(res.task_burst))
    else $error("dispatch times inconsistent");

endmodule

bind shortest_job_first_dispatcher sjf_checker u_sjf_checker (.*);
`default_nettype wire
